// ----- src/arq_pkg.sv -----
`timescale 1ns / 1ps
package arq_pkg;
  localparam int QueueSlots = 32;
  localparam int Players = 8;
  localparam int SlotW = $clog2(QueueSlots);

  typedef enum logic [1:0] {
    REQ_ADD = 2'd0,
    REQ_ACK = 2'd1,
    REQ_SWEEP = 2'd2,
    REQ_CLEAR = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_STORED = 3'd0,
    ST_DROPPED = 3'd1,
    ST_FULL = 3'd2,
    ST_ACKED = 3'd3,
    ST_IGNORED = 3'd4,
    ST_RESEND = 3'd5,
    ST_IDLE = 3'd6,
    ST_CLEARED = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    REG_LOCAL = 3'd0,
    REG_PCOUNT = 3'd1,
    REG_ENABLE = 3'd2,
    REG_SHORT = 3'd3,
    REG_INTERVAL = 3'd4,
    REG_EXPIRY = 3'd5,
    REG_MAXRES = 3'd6
  } reg_e;

  typedef struct packed {
    logic [31:0] pnum;
    logic [31:0] first;
    logic [31:0] lastt;
    logic [Players-1:0] acks;
  } entry_t;
endpackage

// ----- src/ack_retransmit_queue.sv -----
`timescale 1ns / 1ps
// Retransmit queue for urgent packets sent to up to eight players. Each item
// is an add, an ack, a sweep tick or a clear. Slot state lives in one
// 32-entry synchronous RAM (packet number, first and last send time, ack
// bits) with a used bit per slot in flip-flops. Adds, acks and sweeps walk
// the slots in order, each slot visited being read, then evaluated and
// written back; an add stops at the first free slot and an ack stops at its
// first match. A clear is answered straight from idle: dropping the used bits
// suffices, as a free slot's data is never used before it is rewritten.
// A sweep answers one item per resend (at most max_resends, clamped to 1..5)
// or one idle item; every other request answers one item. During a sweep each
// resend is held back until the next one is found or the scan ends, so that
// the final resend can carry last; if the scan stops on a resend, that one is
// released from a separate flush state. Results sit in an output register;
// the scan holds while that register is full and not taken.
module ack_retransmit_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  req_type_i,
  input  logic                        urgent_i,
  input  logic signed [31:0]          packet_number_i,
  input  logic signed [31:0]          now_time_i,
  input  logic [7:0]                  connected_mask_i,
  input  logic [2:0]                  ack_sender_i,
  input  logic [7:0]                  ack_receiver_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [2:0]                  cfg_index_i,
  input  logic [30:0]                 cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [2:0]                  status_o,
  output logic [4:0]                  slot_o,
  output logic signed [31:0]          packet_number_out_o,
  output logic [7:0]                  target_mask_o,
  output logic                        last_o
);
  import arq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_FLUSH} state_e;

  // Configuration registers.
  logic [2:0]  local_q;
  logic [3:0]  pcount_q;
  logic        enable_q, short_q;
  logic [30:0] interval_q, expiry_q;
  logic [2:0]  maxres_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= '0;
      pcount_q <= 4'd1;
      enable_q <= 1'b1;
      short_q <= 1'b0;
      interval_q <= 31'd65536;
      expiry_q <= 31'd983040;
      maxres_q <= 3'd5;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_LOCAL:    local_q <= cfg_data_i[2:0];
        REG_PCOUNT:   pcount_q <= cfg_data_i[3:0];
        REG_ENABLE:   enable_q <= cfg_data_i[0];
        REG_SHORT:    short_q <= cfg_data_i[0];
        REG_INTERVAL: interval_q <= cfg_data_i;
        REG_EXPIRY:   expiry_q <= cfg_data_i;
        REG_MAXRES:   maxres_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // Slot RAM, one read and one write port.
  entry_t mem_q [QueueSlots];
  entry_t rd_q;
  logic we;
  logic [SlotW-1:0] wa;
  entry_t wd;

  logic [QueueSlots-1:0] used_q, used_d;

  state_e state_q, state_d;
  logic [1:0] req_q, req_d;
  logic [31:0] pnum_q, pnum_d, now_q, now_d;
  logic [7:0] conn_q, conn_d;
  logic [2:0] sender_q, sender_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [2:0] count_q, count_d;
  logic ov_q, ov_d;
  logic [2:0] st_q, st_d;
  logic [4:0] slot_q, slot_d;
  logic [31:0] pout_q, pout_d;
  logic [7:0] tgt_q, tgt_d;
  logic last_q, last_d;
  // Resend waiting until it is known whether it is the final one.
  logic hold_q, hold_d;
  logic [4:0] hslot_q, hslot_d;
  logic [31:0] hpnum_q, hpnum_d;
  logic [7:0] htgt_q, htgt_d;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[idx_q];
  end

  // Sweep derived values.
  logic [3:0] pc_sat;
  logic [2:0] limit;
  logic [7:0] check, remote;
  always_comb begin
    pc_sat = (pcount_q > 4'd8) ? 4'd8 : pcount_q;
    limit = (maxres_q == 3'd0) ? 3'd1 : ((maxres_q > 3'd5) ? 3'd5 : maxres_q);
    check = 8'((9'd1 << pc_sat) - 9'd1);
    remote = check & ~(8'd1 << local_q);
  end

  logic signed [33:0] now_s, first_s, last_s, expiry_s, interval_s;
  logic expire, due, pending;
  logic [7:0] acks_new;
  assign now_s = 34'(signed'(now_q));
  assign first_s = 34'(signed'(rd_q.first));
  assign last_s = 34'(signed'(rd_q.lastt));
  assign expiry_s = signed'({3'b000, expiry_q});
  assign interval_s = signed'({3'b000, interval_q});
  assign pending = ((~rd_q.acks) & conn_q & remote) != 8'd0;
  assign expire = !pending || (first_s + expiry_s <= now_s) || (now_s < first_s);
  assign due = (last_s + interval_s <= now_s) || (now_s < last_s);
  assign acks_new = rd_q.acks | ((~conn_q) & check);

  logic out_free;
  assign out_free = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE) && out_free;
  assign out_valid_o = ov_q;
  assign status_o = st_q;
  assign slot_o = slot_q;
  assign packet_number_out_o = pout_q;
  assign target_mask_o = tgt_q;
  assign last_o = last_q;

  logic at_end;
  assign at_end = (idx_q == SlotW'(QueueSlots - 1));

  always_comb begin
    state_d = state_q; req_d = req_q; pnum_d = pnum_q; now_d = now_q;
    conn_d = conn_q; sender_d = sender_q; idx_d = idx_q; count_d = count_q;
    used_d = used_q;
    ov_d = ov_q && !out_ready_i;
    st_d = st_q; slot_d = slot_q; pout_d = pout_q; tgt_d = tgt_q; last_d = last_q;
    hold_d = hold_q; hslot_d = hslot_q; hpnum_d = hpnum_q; htgt_d = htgt_q;
    we = 1'b0; wa = idx_q; wd = rd_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          req_d = req_type_i; pnum_d = packet_number_i; now_d = now_time_i;
          conn_d = connected_mask_i; sender_d = ack_sender_i;
          idx_d = '0; count_d = '0; hold_d = 1'b0;
          ov_d = 1'b1; slot_d = '0; pout_d = '0; tgt_d = '0; last_d = 1'b1;
          case (req_type_i)
            REQ_ADD: begin
              if (!enable_q || !urgent_i) begin
                st_d = ST_DROPPED;
              end else begin
                ov_d = 1'b0;
                state_d = S_READ;
              end
            end
            REQ_ACK: begin
              if (ack_receiver_i == {5'd0, local_q}) begin
                ov_d = 1'b0;
                state_d = S_READ;
              end else begin
                st_d = ST_IGNORED;
              end
            end
            REQ_SWEEP: begin
              ov_d = 1'b0;
              state_d = S_READ;
            end
            default: begin
              used_d = '0;
              st_d = ST_CLEARED;
            end
          endcase
        end
      end
      S_READ: state_d = S_EVAL;
      S_EVAL: begin
        // rd_q holds entry idx_q here.
        if (out_free) begin
          logic fin, flush;
          fin = 1'b0;
          flush = 1'b0;
          case (req_q)
            REQ_ADD: begin
              if (!used_q[idx_q]) begin
                used_d[idx_q] = 1'b1;
                we = 1'b1;
                wd.pnum = pnum_q; wd.first = now_q; wd.lastt = now_q;
                wd.acks = ~conn_q;
                ov_d = 1'b1; st_d = ST_STORED; slot_d = 5'(idx_q);
                pout_d = pnum_q; tgt_d = '0; last_d = 1'b1;
                fin = 1'b1;
              end else if (at_end) begin
                ov_d = 1'b1; st_d = ST_FULL; slot_d = '0; pout_d = '0;
                tgt_d = '0; last_d = 1'b1;
                fin = 1'b1;
              end
            end
            REQ_ACK: begin
              if (used_q[idx_q] && rd_q.pnum == pnum_q) begin
                we = 1'b1;
                wd.acks = rd_q.acks | (8'd1 << sender_q);
                ov_d = 1'b1; st_d = ST_ACKED; slot_d = 5'(idx_q);
                pout_d = pnum_q; tgt_d = '0; last_d = 1'b1;
                fin = 1'b1;
              end else if (at_end) begin
                ov_d = 1'b1; st_d = ST_IGNORED; slot_d = '0; pout_d = '0;
                tgt_d = '0; last_d = 1'b1;
                fin = 1'b1;
              end
            end
            default: begin
              logic sent;
              sent = 1'b0;
              if (used_q[idx_q]) begin
                if (expire) begin
                  used_d[idx_q] = 1'b0;
                end else if (due) begin
                  sent = 1'b1;
                  we = 1'b1;
                  wd.lastt = now_q;
                  wd.acks = acks_new;
                  count_d = count_q + 3'd1;
                  // Release the previous resend, not last; hold the new one.
                  if (hold_q) begin
                    ov_d = 1'b1; st_d = ST_RESEND; slot_d = hslot_q;
                    pout_d = hpnum_q; tgt_d = htgt_q; last_d = 1'b0;
                  end
                  hold_d = 1'b1; hslot_d = 5'(idx_q); hpnum_d = rd_q.pnum;
                  htgt_d = short_q ? (conn_q & remote) : (~acks_new & conn_q & remote);
                end
              end
              if (sent && (at_end || (count_q + 3'd1 >= limit))) begin
                flush = 1'b1;
              end else if (at_end) begin
                fin = 1'b1;
                ov_d = 1'b1; last_d = 1'b1;
                if (hold_q) begin
                  st_d = ST_RESEND; slot_d = hslot_q; pout_d = hpnum_q;
                  tgt_d = htgt_q; hold_d = 1'b0;
                end else begin
                  st_d = ST_IDLE; slot_d = '0; pout_d = '0; tgt_d = '0;
                end
              end
            end
          endcase
          if (flush) begin
            state_d = S_FLUSH;
          end else if (fin) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_FLUSH: begin
        // Send the held resend as the final item of the sweep.
        if (out_free) begin
          ov_d = 1'b1; st_d = ST_RESEND; slot_d = hslot_q; pout_d = hpnum_q;
          tgt_d = htgt_q; last_d = 1'b1; hold_d = 1'b0;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q <= '0;
      ov_q <= 1'b0;
      idx_q <= '0;
      count_q <= '0;
      req_q <= '0;
      hold_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q <= used_d;
      ov_q <= ov_d;
      idx_q <= idx_d;
      count_q <= count_d;
      req_q <= req_d;
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pnum_q <= pnum_d; now_q <= now_d; conn_q <= conn_d; sender_q <= sender_d;
    st_q <= st_d; slot_q <= slot_d; pout_q <= pout_d; tgt_q <= tgt_d;
    last_q <= last_d;
    hslot_q <= hslot_d; hpnum_q <= hpnum_d; htgt_q <= htgt_d;
  end

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == S_IDLE) else $error("ready outside idle");
  a_count_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd5) else $error("resend count overflow");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && req_type_i == REQ_CLEAR) |=> used_q == '0)
    else $error("clear left used slots");
  a_flush_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH |-> hold_q) else $error("flush without held resend");
`endif
endmodule
